// ===== rtl/ehist_pkg.sv =====
// Shared types and constants for the edge interval histogram.
// Used by ehist_stats, ehist_bin_store and edge_interval_histogram.
package ehist_pkg;

	localparam int NUM_BINS    = 128;
	localparam int BIN_AW      = $clog2(NUM_BINS);
	localparam int TIMER_BITS  = 16;
	localparam int COUNT_BITS  = 16;
	localparam int SAMPLE_BITS = 11;
	localparam int MAX_SAMPLES = 1024;

	localparam logic [TIMER_BITS-1:0]  RESET_BIN_BASE     = TIMER_BITS'(950);
	localparam logic [SAMPLE_BITS-1:0] RESET_SAMPLE_COUNT = SAMPLE_BITS'(1000);
	localparam logic [TIMER_BITS-1:0]  MIN_START          = '1;
	localparam logic [COUNT_BITS-1:0]  COUNT_MAX          = '1;

	typedef enum logic [1:0] {
		OP_EDGE  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		REG_BIN_BASE     = 1'b0,
		REG_SAMPLE_COUNT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic              acc;
		logic              rd;
		logic              inc;
		logic              clr;
		logic [BIN_AW-1:0] addr;
	} bin_req_t;

	typedef struct packed {
		logic [TIMER_BITS-1:0]  min_iv;
		logic [TIMER_BITS-1:0]  max_iv;
		logic                   done;
		logic [SAMPLE_BITS-1:0] outside;
		logic [SAMPLE_BITS-1:0] taken;
	} status_t;

endpackage

// ===== rtl/ehist_stats.sv =====
// Interval computation, scalar statistics and configuration registers.
// Issues bin store requests; depends on ehist_pkg.
module ehist_stats (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic [1:0]                          opcode,
	input  logic [ehist_pkg::TIMER_BITS-1:0]    timestamp,
	input  logic [6:0]                          bin_index,
	input  logic                                cfg_we,
	input  logic [0:0]                          cfg_index,
	input  logic [15:0]                         cfg_wdata,
	output logic [ehist_pkg::TIMER_BITS-1:0]    interval,
	output logic                                interval_valid,
	output logic                                read_hit,
	output ehist_pkg::bin_req_t                 bin_req,
	output ehist_pkg::status_t                  status
);

	logic [ehist_pkg::TIMER_BITS-1:0]  bin_base_q;
	logic [ehist_pkg::SAMPLE_BITS-1:0] sample_count_q;
	logic [ehist_pkg::TIMER_BITS-1:0]  last_q, nxt_last;
	logic                              have_q, nxt_have;
	logic [ehist_pkg::SAMPLE_BITS-1:0] taken_q, nxt_taken;
	logic [ehist_pkg::SAMPLE_BITS-1:0] outside_q, nxt_outside;
	logic [ehist_pkg::TIMER_BITS-1:0]  min_q, nxt_min;
	logic [ehist_pkg::TIMER_BITS-1:0]  max_q, nxt_max;
	logic [ehist_pkg::SAMPLE_BITS-1:0] limit;
	logic [ehist_pkg::TIMER_BITS-1:0]  interval_c;
	logic [ehist_pkg::TIMER_BITS:0]    diff;
	logic                              in_bins;
	logic                              take;
	logic                              room;
	logic                              idx_ok;

	assign limit = (sample_count_q > ehist_pkg::SAMPLE_BITS'(ehist_pkg::MAX_SAMPLES)) ?
		ehist_pkg::SAMPLE_BITS'(ehist_pkg::MAX_SAMPLES) : sample_count_q;
	assign interval_c = timestamp - last_q;
	assign diff = {1'b0, interval_c} - {1'b0, bin_base_q};
	assign in_bins = !diff[ehist_pkg::TIMER_BITS] &&
		(diff < (ehist_pkg::TIMER_BITS+1)'(ehist_pkg::NUM_BINS));
	assign room = taken_q < limit;
	assign idx_ok = 32'(bin_index) < 32'(ehist_pkg::NUM_BINS);

	always_comb begin
		nxt_last    = last_q;
		nxt_have    = have_q;
		nxt_taken   = taken_q;
		nxt_outside = outside_q;
		nxt_min     = min_q;
		nxt_max     = max_q;
		take        = 1'b0;
		case (opcode)
			ehist_pkg::OP_EDGE: begin
				if (room) begin
					nxt_last = timestamp;
					nxt_have = 1'b1;
					if (have_q) begin
						take = 1'b1;
						if (!in_bins)
							nxt_outside = outside_q + 1'b1;
						if (interval_c < min_q)
							nxt_min = interval_c;
						if (interval_c > max_q)
							nxt_max = interval_c;
						nxt_taken = taken_q + 1'b1;
					end
				end
			end
			ehist_pkg::OP_CLEAR: begin
				nxt_last    = '0;
				nxt_have    = 1'b0;
				nxt_taken   = '0;
				nxt_outside = '0;
				nxt_min     = ehist_pkg::MIN_START;
				nxt_max     = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_base_q     <= ehist_pkg::RESET_BIN_BASE;
			sample_count_q <= ehist_pkg::RESET_SAMPLE_COUNT;
		end else if (cfg_we) begin
			if (cfg_index == ehist_pkg::REG_BIN_BASE)
				bin_base_q <= cfg_wdata[ehist_pkg::TIMER_BITS-1:0];
			else
				sample_count_q <= cfg_wdata[ehist_pkg::SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			have_q    <= 1'b0;
			taken_q   <= '0;
			outside_q <= '0;
			min_q     <= ehist_pkg::MIN_START;
			max_q     <= '0;
		end else if (accept) begin
			last_q    <= nxt_last;
			have_q    <= nxt_have;
			taken_q   <= nxt_taken;
			outside_q <= nxt_outside;
			min_q     <= nxt_min;
			max_q     <= nxt_max;
		end
	end

	assign interval       = take ? interval_c : '0;
	assign interval_valid = take;
	assign read_hit       = (opcode == ehist_pkg::OP_READ) && idx_ok;

	assign bin_req.acc  = accept;
	assign bin_req.rd   = accept && (read_hit || (take && in_bins));
	assign bin_req.inc  = accept && take && in_bins;
	assign bin_req.clr  = accept && (opcode == ehist_pkg::OP_CLEAR);
	assign bin_req.addr = (opcode == ehist_pkg::OP_READ) ?
		bin_index[ehist_pkg::BIN_AW-1:0] : diff[ehist_pkg::BIN_AW-1:0];

	assign status.min_iv  = nxt_min;
	assign status.max_iv  = nxt_max;
	assign status.done    = nxt_taken >= limit;
	assign status.outside = nxt_outside;
	assign status.taken   = nxt_taken;

	a_taken_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(taken_q) <= ehist_pkg::MAX_SAMPLES)
		else $error("sample counter past limit");
	a_outside_le_taken: assert property (@(posedge clk) disable iff (!arst_n)
		outside_q <= taken_q)
		else $error("outside count exceeds taken count");
	a_no_prev_no_taken: assert property (@(posedge clk) disable iff (!arst_n)
		!have_q |-> (taken_q == '0))
		else $error("intervals counted without a previous capture");
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(taken_q != '0) |-> (min_q <= max_q))
		else $error("min above max");

endmodule

// ===== rtl/ehist_bin_store.sv =====
// Histogram bin memory with per-entry valid flags, read-modify-write and
// write-to-read forwarding. Depends on ehist_pkg.
module ehist_bin_store (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ehist_pkg::bin_req_t                req,
	input  logic                               advance,
	output logic [ehist_pkg::COUNT_BITS-1:0]   count_s1
);

	logic [ehist_pkg::COUNT_BITS-1:0] mem [ehist_pkg::NUM_BINS];
	logic [ehist_pkg::NUM_BINS-1:0]   vld_q;
	logic [ehist_pkg::COUNT_BITS-1:0] ram_s1;
	logic [ehist_pkg::BIN_AW-1:0]     addr_s1;
	logic                             inc_s1;
	logic                             vld_s1;
	logic                             fwd_s1;
	logic [ehist_pkg::COUNT_BITS-1:0] fwd_data_s1;
	logic                             wr_en;
	logic [ehist_pkg::COUNT_BITS-1:0] wr_data;

	assign count_s1 = fwd_s1 ? fwd_data_s1 : (vld_s1 ? ram_s1 : '0);
	assign wr_en    = advance && inc_s1;
	assign wr_data  = (count_s1 == ehist_pkg::COUNT_MAX) ? count_s1 : count_s1 + 1'b1;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr_s1] <= wr_data;
		if (req.acc)
			ram_s1 <= mem[req.addr];
	end

	always_ff @(posedge clk) begin
		if (req.acc) begin
			addr_s1     <= req.addr;
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_s1 <= 1'b0;
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (req.acc) begin
			inc_s1 <= req.inc;
			vld_s1 <= req.rd && vld_q[req.addr];
			fwd_s1 <= req.rd && wr_en && (addr_s1 == req.addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (req.clr)
			vld_q <= '0;
		else if (wr_en)
			vld_q[addr_s1] <= 1'b1;
	end

endmodule

// ===== rtl/edge_interval_histogram.sv =====
// Edge interval histogram: top level with stream handshake and output register.
// Path: a request's result is registered in stage s1 and then in the output register.
// Throughput: one request per cycle unless the output stalls; the bin memory's single
// read-modify-write of one entry per request sets that figure, with forwarding between neighbors.
// Reset: asynchronous; bin valid flags clear at once, bin_base 950, sample_count 1000.
// Depends on ehist_pkg, ehist_stats and ehist_bin_store.
module edge_interval_histogram (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // timestamp[15:0], bin_index[22:16], zero[23]
	input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,  // interval[15:0], bin_count[31:16],
	                                   // min_interval[47:32], max_interval[63:48],
	                                   // capture_done[64], outside_count[75:65],
	                                   // taken_count[86:76], zero[87]
	output logic [0:0]  m_axis_tuser,  // interval_valid[0]
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic                                accept;
	logic                                s1_leave;
	logic                                v_s1;
	logic                                out_v_q;
	logic [ehist_pkg::TIMER_BITS-1:0]    interval_c;
	logic                                ivalid_c;
	logic                                read_hit_c;
	ehist_pkg::bin_req_t                 bin_req;
	ehist_pkg::status_t                  status_c;
	logic [ehist_pkg::COUNT_BITS-1:0]    count_s1;
	logic [ehist_pkg::TIMER_BITS-1:0]    interval_s1;
	logic                                ivalid_s1;
	logic                                read_hit_s1;
	ehist_pkg::status_t                  status_s1;
	logic [87:0]                         data_q;
	logic                                user_q;

	assign s1_leave      = v_s1 && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || s1_leave;
	assign accept        = s_axis_tvalid && s_axis_tready;

	ehist_stats u_stats (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.opcode         (s_axis_tuser),
		.timestamp      (s_axis_tdata[15:0]),
		.bin_index      (s_axis_tdata[22:16]),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.interval       (interval_c),
		.interval_valid (ivalid_c),
		.read_hit       (read_hit_c),
		.bin_req        (bin_req),
		.status         (status_c)
	);

	ehist_bin_store u_bins (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (bin_req),
		.advance  (s1_leave),
		.count_s1 (count_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (accept)
			v_s1 <= 1'b1;
		else if (s1_leave)
			v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			interval_s1 <= interval_c;
			ivalid_s1   <= ivalid_c;
			read_hit_s1 <= read_hit_c;
			status_s1   <= status_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (s1_leave)
			out_v_q <= 1'b1;
		else if (m_axis_tready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_leave) begin
			data_q <= {1'b0, status_s1.taken, status_s1.outside, status_s1.done,
				status_s1.max_iv, status_s1.min_iv,
				(read_hit_s1 ? count_s1 : {ehist_pkg::COUNT_BITS{1'b0}}),
				interval_s1};
			user_q <= ivalid_s1;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;

endmodule
